/* sv/array_list_engine_macros.svh */
// Assertion macros used by the checker of the list engine.
// No dependencies; include by bare file name.
`ifndef ARRAY_LIST_ENGINE_MACROS_SVH
`define ARRAY_LIST_ENGINE_MACROS_SVH

// consequent checked on the same clock edge as the antecedent
`define ALE_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// consequent checked on the clock edge after the antecedent
`define ALE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/ale_pkg.sv */
// Shared types and codes of the list engine: command and status codes,
// controller-to-datapath command and status structs. No dependencies.
package ale_pkg;

  localparam int unsigned ValueW    = 32;
  localparam int unsigned PosW      = 8;
  localparam int unsigned IndexOutW = 8;
  localparam int unsigned CountOutW = 9;

  typedef enum logic [3:0] {
    CMD_CREATE    = 4'd0,
    CMD_APPEND    = 4'd1,
    CMD_DELETE    = 4'd2,
    CMD_REVERSE   = 4'd3,
    CMD_SORT      = 4'd4,
    CMD_SEARCH    = 4'd5,
    CMD_READ      = 4'd6,
    CMD_MATCHLIST = 4'd7,
    CMD_DUMP      = 4'd8,
    CMD_COUNT     = 4'd9
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_BAD_INDEX = 2'd2,
    ST_FULL      = 2'd3
  } status_e;

  typedef enum logic [1:0] {CNT_HOLD, CNT_ONE, CNT_INC, CNT_DEC} cnt_op_e;
  typedef enum logic [1:0] {I_HOLD, I_ZERO, I_INC} i_op_e;
  typedef enum logic [2:0] {J_HOLD, J_LAST, J_IP1, J_INC, J_DEC} j_op_e;
  typedef enum logic [1:0] {RD_I, RD_IP1, RD_J, RD_POS} rd_sel_e;
  typedef enum logic [1:0] {WA_I, WA_J, WA_CNT, WA_ZERO} wa_sel_e;
  typedef enum logic [1:0] {WD_OP, WD_RDATA, WD_HOLD} wd_sel_e;
  typedef enum logic [2:0] {IDX_ZERO, IDX_I, IDX_T, IDX_POS, IDX_CNT} idx_sel_e;
  typedef enum logic [1:0] {VAL_ZERO, VAL_OP, VAL_RDATA} val_sel_e;

  typedef struct packed {
    logic     latch_in;
    cnt_op_e  cnt_op;
    i_op_e    i_op;
    j_op_e    j_op;
    logic     rd_en;
    rd_sel_e  rd_sel;
    logic     wr_en;
    wa_sel_e  wa_sel;
    wd_sel_e  wd_sel;
    logic     hold_ld;
    logic     t_ld;
    logic     emit;
    status_e  emit_status;
    idx_sel_e idx_sel;
    val_sel_e val_sel;
    logic     emit_last;
  } dp_cmd_t;

  typedef struct packed {
    logic slot_free;  // output register can take a beat this cycle
    logic i_eq_cnt;
    logic i_ge_last;  // i + 1 >= count
    logic i_eq_t;
    logic i_ge_j;
    logic j_eq_cnt;
    logic hit;        // read data equals operand
    logic greater;    // hold > read data, signed
    logic pos_bad;
    logic cnt_zero;
    logic cnt_full;
  } dp_stat_t;

endpackage

/* sv/ale_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module ale_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* sv/ale_ctrl.sv */
// Command sequencer of the list engine: one state machine that walks the
// list for each command and drives the datapath. Depends on ale_pkg.
module ale_ctrl
  import ale_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  logic [3:0] cmd_i,
  input  dp_stat_t stat_i,
  output dp_cmd_t  dp_cmd_o,
  output logic     busy_o
);

  typedef enum logic [4:0] {
    S_IDLE, S_CREATE, S_APPEND, S_SCAN_RD, S_SCAN_CHK, S_SHIFT_RD, S_SHIFT_WR,
    S_REV_RI, S_REV_RJ, S_REV_WI, S_REV_WJ, S_SORT_I, S_SORT_LD, S_SORT_J,
    S_SORT_CMP, S_READ, S_READ_EM, S_ML_RD, S_ML_CHK, S_DUMP_RD, S_DUMP_EM,
    S_COUNT
  } state_e;

  state_e state_q, state_d;
  cmd_e   cmd_q, cmd_d;
  logic   ml_hit_q, ml_hit_d;

  always_comb begin
    state_d  = state_q;
    cmd_d    = cmd_q;
    ml_hit_d = ml_hit_q;
    dp_cmd_o = '0;
    dp_cmd_o.emit_last = 1'b1;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          dp_cmd_o.latch_in = 1'b1;
          dp_cmd_o.i_op     = I_ZERO;
          dp_cmd_o.j_op     = J_LAST;
          ml_hit_d          = 1'b0;
          cmd_d             = cmd_e'(cmd_i);
          case (cmd_e'(cmd_i))
            CMD_CREATE:                            state_d = S_CREATE;
            CMD_APPEND:                            state_d = S_APPEND;
            CMD_DELETE, CMD_SEARCH, CMD_MATCHLIST: state_d = S_SCAN_RD;
            CMD_REVERSE:                           state_d = S_REV_RI;
            CMD_SORT:                              state_d = S_SORT_I;
            CMD_READ:                              state_d = S_READ;
            CMD_DUMP:                              state_d = S_DUMP_RD;
            CMD_COUNT:                             state_d = S_COUNT;
            default:                               state_d = S_IDLE;
          endcase
        end
      end

      S_CREATE: begin
        if (stat_i.slot_free) begin
          dp_cmd_o.wr_en   = 1'b1;
          dp_cmd_o.wa_sel  = WA_ZERO;
          dp_cmd_o.wd_sel  = WD_OP;
          dp_cmd_o.cnt_op  = CNT_ONE;
          dp_cmd_o.emit    = 1'b1;
          dp_cmd_o.idx_sel = IDX_ZERO;
          dp_cmd_o.val_sel = VAL_OP;
          state_d          = S_IDLE;
        end
      end

      S_APPEND: begin
        if (stat_i.slot_free) begin
          dp_cmd_o.emit    = 1'b1;
          dp_cmd_o.val_sel = VAL_OP;
          if (stat_i.cnt_full) begin
            dp_cmd_o.emit_status = ST_FULL;
            dp_cmd_o.idx_sel     = IDX_ZERO;
          end else begin
            dp_cmd_o.wr_en   = 1'b1;
            dp_cmd_o.wa_sel  = WA_CNT;
            dp_cmd_o.wd_sel  = WD_OP;
            dp_cmd_o.cnt_op  = CNT_INC;
            dp_cmd_o.idx_sel = IDX_CNT;
          end
          state_d = S_IDLE;
        end
      end

      // first pass for delete, search and match-list
      S_SCAN_RD: begin
        if (stat_i.i_eq_cnt) begin
          if (cmd_q == CMD_MATCHLIST && ml_hit_q) begin
            dp_cmd_o.i_op = I_ZERO;
            state_d       = S_ML_RD;
          end else if (stat_i.slot_free) begin
            dp_cmd_o.emit        = 1'b1;
            dp_cmd_o.emit_status = ST_NOT_FOUND;
            dp_cmd_o.idx_sel     = IDX_ZERO;
            dp_cmd_o.val_sel     = VAL_OP;
            state_d              = S_IDLE;
          end
        end else begin
          dp_cmd_o.rd_en  = 1'b1;
          dp_cmd_o.rd_sel = RD_I;
          state_d         = S_SCAN_CHK;
        end
      end

      S_SCAN_CHK: begin
        if (stat_i.hit) begin
          case (cmd_q)
            CMD_DELETE: begin
              dp_cmd_o.t_ld = 1'b1;
              state_d       = S_SHIFT_RD;
            end
            CMD_SEARCH: begin
              if (stat_i.slot_free) begin
                dp_cmd_o.emit    = 1'b1;
                dp_cmd_o.idx_sel = IDX_I;
                dp_cmd_o.val_sel = VAL_OP;
                state_d          = S_IDLE;
              end
            end
            default: begin
              // remember the last match so the second pass can flag it
              ml_hit_d      = 1'b1;
              dp_cmd_o.t_ld = 1'b1;
              dp_cmd_o.i_op = I_INC;
              state_d       = S_SCAN_RD;
            end
          endcase
        end else begin
          dp_cmd_o.i_op = I_INC;
          state_d       = S_SCAN_RD;
        end
      end

      S_SHIFT_RD: begin
        if (stat_i.i_ge_last) begin
          if (stat_i.slot_free) begin
            dp_cmd_o.cnt_op  = CNT_DEC;
            dp_cmd_o.emit    = 1'b1;
            dp_cmd_o.idx_sel = IDX_T;
            dp_cmd_o.val_sel = VAL_OP;
            state_d          = S_IDLE;
          end
        end else begin
          dp_cmd_o.rd_en  = 1'b1;
          dp_cmd_o.rd_sel = RD_IP1;
          state_d         = S_SHIFT_WR;
        end
      end

      S_SHIFT_WR: begin
        dp_cmd_o.wr_en  = 1'b1;
        dp_cmd_o.wa_sel = WA_I;
        dp_cmd_o.wd_sel = WD_RDATA;
        dp_cmd_o.i_op   = I_INC;
        state_d         = S_SHIFT_RD;
      end

      S_REV_RI: begin
        if (stat_i.i_ge_j) begin
          if (stat_i.slot_free) begin
            dp_cmd_o.emit = 1'b1;
            state_d       = S_IDLE;
          end
        end else begin
          dp_cmd_o.rd_en  = 1'b1;
          dp_cmd_o.rd_sel = RD_I;
          state_d         = S_REV_RJ;
        end
      end

      S_REV_RJ: begin
        dp_cmd_o.hold_ld = 1'b1;
        dp_cmd_o.rd_en   = 1'b1;
        dp_cmd_o.rd_sel  = RD_J;
        state_d          = S_REV_WI;
      end

      S_REV_WI: begin
        dp_cmd_o.wr_en  = 1'b1;
        dp_cmd_o.wa_sel = WA_I;
        dp_cmd_o.wd_sel = WD_RDATA;
        state_d         = S_REV_WJ;
      end

      S_REV_WJ: begin
        dp_cmd_o.wr_en  = 1'b1;
        dp_cmd_o.wa_sel = WA_J;
        dp_cmd_o.wd_sel = WD_HOLD;
        dp_cmd_o.i_op   = I_INC;
        dp_cmd_o.j_op   = J_DEC;
        state_d         = S_REV_RI;
      end

      // hold carries the running minimum of entry i across the inner walk
      S_SORT_I: begin
        if (stat_i.i_ge_last) begin
          if (stat_i.slot_free) begin
            dp_cmd_o.emit = 1'b1;
            state_d       = S_IDLE;
          end
        end else begin
          dp_cmd_o.rd_en  = 1'b1;
          dp_cmd_o.rd_sel = RD_I;
          dp_cmd_o.j_op   = J_IP1;
          state_d         = S_SORT_LD;
        end
      end

      S_SORT_LD: begin
        dp_cmd_o.hold_ld = 1'b1;
        state_d          = S_SORT_J;
      end

      S_SORT_J: begin
        if (stat_i.j_eq_cnt) begin
          dp_cmd_o.wr_en  = 1'b1;
          dp_cmd_o.wa_sel = WA_I;
          dp_cmd_o.wd_sel = WD_HOLD;
          dp_cmd_o.i_op   = I_INC;
          state_d         = S_SORT_I;
        end else begin
          dp_cmd_o.rd_en  = 1'b1;
          dp_cmd_o.rd_sel = RD_J;
          state_d         = S_SORT_CMP;
        end
      end

      S_SORT_CMP: begin
        if (stat_i.greater) begin
          dp_cmd_o.wr_en   = 1'b1;
          dp_cmd_o.wa_sel  = WA_J;
          dp_cmd_o.wd_sel  = WD_HOLD;
          dp_cmd_o.hold_ld = 1'b1;
        end
        dp_cmd_o.j_op = J_INC;
        state_d       = S_SORT_J;
      end

      S_READ: begin
        if (stat_i.pos_bad) begin
          if (stat_i.slot_free) begin
            dp_cmd_o.emit        = 1'b1;
            dp_cmd_o.emit_status = ST_BAD_INDEX;
            dp_cmd_o.idx_sel     = IDX_POS;
            state_d              = S_IDLE;
          end
        end else begin
          dp_cmd_o.rd_en  = 1'b1;
          dp_cmd_o.rd_sel = RD_POS;
          state_d         = S_READ_EM;
        end
      end

      S_READ_EM: begin
        if (stat_i.slot_free) begin
          dp_cmd_o.emit    = 1'b1;
          dp_cmd_o.idx_sel = IDX_POS;
          dp_cmd_o.val_sel = VAL_RDATA;
          state_d          = S_IDLE;
        end
      end

      S_ML_RD: begin
        dp_cmd_o.rd_en  = 1'b1;
        dp_cmd_o.rd_sel = RD_I;
        state_d         = S_ML_CHK;
      end

      S_ML_CHK: begin
        if (stat_i.hit) begin
          if (stat_i.slot_free) begin
            dp_cmd_o.emit      = 1'b1;
            dp_cmd_o.idx_sel   = IDX_I;
            dp_cmd_o.val_sel   = VAL_OP;
            dp_cmd_o.emit_last = stat_i.i_eq_t;
            if (stat_i.i_eq_t) begin
              state_d = S_IDLE;
            end else begin
              dp_cmd_o.i_op = I_INC;
              state_d       = S_ML_RD;
            end
          end
        end else begin
          dp_cmd_o.i_op = I_INC;
          state_d       = S_ML_RD;
        end
      end

      S_DUMP_RD: begin
        if (stat_i.cnt_zero) begin
          if (stat_i.slot_free) begin
            dp_cmd_o.emit        = 1'b1;
            dp_cmd_o.emit_status = ST_NOT_FOUND;
            state_d              = S_IDLE;
          end
        end else begin
          dp_cmd_o.rd_en  = 1'b1;
          dp_cmd_o.rd_sel = RD_I;
          state_d         = S_DUMP_EM;
        end
      end

      S_DUMP_EM: begin
        if (stat_i.slot_free) begin
          dp_cmd_o.emit      = 1'b1;
          dp_cmd_o.idx_sel   = IDX_I;
          dp_cmd_o.val_sel   = VAL_RDATA;
          dp_cmd_o.emit_last = stat_i.i_ge_last;
          if (stat_i.i_ge_last) begin
            state_d = S_IDLE;
          end else begin
            dp_cmd_o.i_op = I_INC;
            state_d       = S_DUMP_RD;
          end
        end
      end

      S_COUNT: begin
        if (stat_i.slot_free) begin
          dp_cmd_o.emit = 1'b1;
          state_d       = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      cmd_q    <= CMD_CREATE;
      ml_hit_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      cmd_q    <= cmd_d;
      ml_hit_q <= ml_hit_d;
    end
  end

  assign busy_o = (state_q != S_IDLE);

endmodule

/* sv/ale_dp.sv */
// Datapath of the list engine: element RAM, count, walk indices, hold
// register and the output register. Depends on ale_pkg and ale_ram.
module ale_dp
  import ale_pkg::*;
#(
  parameter int unsigned DEPTH = 64
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  dp_cmd_t              cmd_i,
  output dp_stat_t             stat_o,
  input  logic [ValueW-1:0]    operand_value_i,
  input  logic [PosW-1:0]      position_i,
  input  logic                 out_stall_i,
  output logic                 out_valid_o,
  output logic [1:0]           status_o,
  output logic [IndexOutW-1:0] found_index_o,
  output logic [ValueW-1:0]    element_value_o,
  output logic [CountOutW-1:0] element_count_o,
  output logic                 last_o
);

  localparam int unsigned IW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [CW-1:0]        cnt_q, cnt_d;
  logic [CW-1:0]        i_q, i_d;
  logic [CW-1:0]        j_q, j_d;
  logic [IW-1:0]        t_q;
  logic [ValueW-1:0]    op_q;
  logic [PosW-1:0]      pos_q;
  logic [ValueW-1:0]    hold_q;
  logic [CW:0]          i_p1;
  logic [CW-1:0]        j_last;
  logic [ValueW-1:0]    rdata;
  logic [IW-1:0]        raddr, waddr;
  logic [ValueW-1:0]    wdata;
  logic                 out_valid_q;
  status_e              out_status_q;
  logic [IndexOutW-1:0] out_idx_q, out_idx_d;
  logic [ValueW-1:0]    out_val_q, out_val_d;
  logic [CountOutW-1:0] out_cnt_q;
  logic                 out_last_q;
  logic                 cnt_zero;

  assign i_p1     = {1'b0, i_q} + (CW + 1)'(1);
  assign cnt_zero = (cnt_q == '0);
  assign j_last   = cnt_zero ? '0 : cnt_q - CW'(1);

  always_comb begin
    case (cmd_i.rd_sel)
      RD_I:    raddr = i_q[IW-1:0];
      RD_IP1:  raddr = i_p1[IW-1:0];
      RD_J:    raddr = j_q[IW-1:0];
      RD_POS:  raddr = pos_q[IW-1:0];
      default: raddr = i_q[IW-1:0];
    endcase
    case (cmd_i.wa_sel)
      WA_I:    waddr = i_q[IW-1:0];
      WA_J:    waddr = j_q[IW-1:0];
      WA_CNT:  waddr = cnt_q[IW-1:0];
      WA_ZERO: waddr = '0;
      default: waddr = '0;
    endcase
    case (cmd_i.wd_sel)
      WD_OP:    wdata = op_q;
      WD_RDATA: wdata = rdata;
      WD_HOLD:  wdata = hold_q;
      default:  wdata = op_q;
    endcase
  end

  ale_ram #(
    .WIDTH (ValueW),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.wr_en),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (cmd_i.rd_en),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  always_comb begin
    case (cmd_i.cnt_op)
      CNT_ONE: cnt_d = CW'(1);
      CNT_INC: cnt_d = cnt_q + CW'(1);
      CNT_DEC: cnt_d = cnt_q - CW'(1);
      default: cnt_d = cnt_q;
    endcase
    case (cmd_i.i_op)
      I_ZERO:  i_d = '0;
      I_INC:   i_d = i_p1[CW-1:0];
      default: i_d = i_q;
    endcase
    case (cmd_i.j_op)
      J_LAST:  j_d = j_last;
      J_IP1:   j_d = i_p1[CW-1:0];
      J_INC:   j_d = j_q + CW'(1);
      J_DEC:   j_d = j_q - CW'(1);
      default: j_d = j_q;
    endcase
    case (cmd_i.idx_sel)
      IDX_I:   out_idx_d = IndexOutW'(i_q);
      IDX_T:   out_idx_d = IndexOutW'(t_q);
      IDX_POS: out_idx_d = pos_q;
      IDX_CNT: out_idx_d = IndexOutW'(cnt_q);
      default: out_idx_d = '0;
    endcase
    case (cmd_i.val_sel)
      VAL_OP:    out_val_d = op_q;
      VAL_RDATA: out_val_d = rdata;
      default:   out_val_d = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    i_q <= i_d;
    j_q <= j_d;
    if (cmd_i.latch_in) begin
      op_q  <= operand_value_i;
      pos_q <= position_i;
    end
    if (cmd_i.t_ld) begin
      t_q <= i_q[IW-1:0];
    end
    if (cmd_i.hold_ld) begin
      hold_q <= rdata;
    end
    // load a beat only when the slot is free; element_count shows the new size
    if (cmd_i.emit) begin
      out_status_q <= cmd_i.emit_status;
      out_idx_q    <= out_idx_d;
      out_val_q    <= out_val_d;
      out_cnt_q    <= CountOutW'(cnt_d);
      out_last_q   <= cmd_i.emit_last;
    end
  end

  always_comb begin
    stat_o.slot_free = !out_valid_q || !out_stall_i;
    stat_o.i_eq_cnt  = (i_q == cnt_q);
    stat_o.i_ge_last = (i_p1 >= {1'b0, cnt_q});
    stat_o.i_eq_t    = (i_q == CW'(t_q));
    stat_o.i_ge_j    = (i_q >= j_q);
    stat_o.j_eq_cnt  = (j_q == cnt_q);
    stat_o.hit       = (rdata == op_q);
    stat_o.greater   = ($signed(hold_q) > $signed(rdata));
    stat_o.pos_bad   = (CountOutW'(pos_q) >= CountOutW'(cnt_q));
    stat_o.cnt_zero  = cnt_zero;
    stat_o.cnt_full  = (cnt_q == CW'(DEPTH));
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = out_status_q;
  assign found_index_o   = out_idx_q;
  assign element_value_o = out_val_q;
  assign element_count_o = out_cnt_q;
  assign last_o          = out_last_q;

endmodule

/* sv/array_list_engine.sv */
// Top level of the list engine: sequencer plus datapath.
// Depends on ale_pkg, ale_ctrl, ale_dp (and ale_ram below it).
//
// Holds a packed list of up to DEPTH signed 32-bit values in one RAM with a
// registered read port and runs one command at a time; in_stall_o stays high
// from the accepted beat until the command has loaded its final result into
// the output register, and a new command is taken while that result still
// waits. Every walk is paced by the single RAM read port: each visited
// entry has a read state, then a check or write state. Delete shifts each
// later entry down with a read and a write, reverse reads and writes both
// ends of each swapped pair, match-list walks again up to its last match,
// sort runs an inner walk per entry, and a result waits out output stalls.
// Codes 10 to 15 are taken and dropped without a result. No clearing pass
// runs after reset; only entries below the count are ever read.
module array_list_engine
  import ale_pkg::*;
#(
  parameter int unsigned DEPTH = 64
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [3:0]                 cmd_i,
  input  logic signed [ValueW-1:0]   operand_value_i,
  input  logic [PosW-1:0]            position_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [1:0]                 status_o,
  output logic [IndexOutW-1:0]       found_index_o,
  output logic signed [ValueW-1:0]   element_value_o,
  output logic [CountOutW-1:0]       element_count_o,
  output logic                       last_o
);

  dp_cmd_t  dp_cmd;
  dp_stat_t dp_stat;
  logic     busy;

  ale_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .cmd_i      (cmd_i),
    .stat_i     (dp_stat),
    .dp_cmd_o   (dp_cmd),
    .busy_o     (busy)
  );

  ale_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (dp_cmd),
    .stat_o          (dp_stat),
    .operand_value_i (operand_value_i),
    .position_i      (position_i),
    .out_stall_i     (out_stall_i),
    .out_valid_o     (out_valid_o),
    .status_o        (status_o),
    .found_index_o   (found_index_o),
    .element_value_o (element_value_o),
    .element_count_o (element_count_o),
    .last_o          (last_o)
  );

  assign in_stall_o = busy;

endmodule

/* sv/ale_checker.sv */
// Port-level checks of the list engine and the bind that attaches them.
// Depends on ale_pkg and array_list_engine_macros.svh.
`include "array_list_engine_macros.svh"

module ale_checker
  import ale_pkg::*;
#(
  parameter int unsigned DEPTH = 64
) (
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     in_valid_i,
  input logic                     in_stall_o,
  input logic [3:0]               cmd_i,
  input logic signed [ValueW-1:0] operand_value_i,
  input logic [PosW-1:0]          position_i,
  input logic                     out_valid_o,
  input logic                     out_stall_i,
  input logic [1:0]               status_o,
  input logic [IndexOutW-1:0]     found_index_o,
  input logic signed [ValueW-1:0] element_value_o,
  input logic [CountOutW-1:0]     element_count_o,
  input logic                     last_o
);

  `ALE_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(status_o) && $stable(found_index_o) && $stable(element_value_o) && $stable(element_count_o) && $stable(last_o), "stalled result beat changed")
  `ALE_ASSERT_SAME(a_count_range, clk_i, rst_ni, out_valid_o, element_count_o <= CountOutW'(DEPTH), "element count above depth")
  `ALE_ASSERT_SAME(a_full_count, clk_i, rst_ni, out_valid_o && status_o == ST_FULL, element_count_o == CountOutW'(DEPTH) && last_o, "full status without full list")
  `ALE_ASSERT_SAME(a_bad_index, clk_i, rst_ni, out_valid_o && status_o == ST_BAD_INDEX, element_value_o == '0 && CountOutW'(found_index_o) >= element_count_o, "bad index below count")
  `ALE_ASSERT_SAME(a_mid_index, clk_i, rst_ni, out_valid_o && !last_o, status_o == ST_OK && CountOutW'(found_index_o) + CountOutW'(1) < element_count_o, "non-final beat out of range")

endmodule

bind array_list_engine ale_checker #(.DEPTH(DEPTH)) u_ale_checker (.*);
